[design/profile_event_counter_bank_macros.svh]
// Assertion macros shared by the profile event counter bank modules.
`ifndef PROFILE_EVENT_COUNTER_BANK_MACROS_SVH
`define PROFILE_EVENT_COUNTER_BANK_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PECB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PECB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pecb_pkg.sv]
// Package with the types, codes and constants of the profile event counter bank.
package pecb_pkg;

   // Default number of counter slots in the store.
   localparam int PECB_SLOTS = 4096;

   // Request actions.
   localparam logic [1:0] ACT_ENTRY = 2'd0;
   localparam logic [1:0] ACT_CALL  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CAPTURE_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_FUNCTION_COUNT  = 2'd1;
   localparam logic [1:0] CSR_CALL_SITE_COUNT = 2'd2;

   // Operation decided for a request once its index has been checked.
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_BUMP = 2'd2;
   localparam logic [1:0] OP_BAD  = 2'd3;

   localparam int CSR_DATA_WIDTH = 13;
   localparam int COUNT_WIDTH    = 13;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] index;
   } req_type;

   typedef struct packed {
      logic [63:0] count_value;
      logic        counted;
      logic        overflow_seen;
      logic        invalid_seen;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load;
      logic check;
      logic read;
      logic exec;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

[design/pecb_controller.sv]
// Controller state machine of the profile event counter bank.
`include "profile_event_counter_bank_macros.svh"

module pecb_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pecb_pkg::status_type status,
   output pecb_pkg::cmd_type    cmd
);
   import pecb_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_EXEC  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // Wait until the result register can take the new response.
            if (status.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // The clearing pass runs only once after reset.
   `PECB_ASSERT_NEXT(a_clear_once, state_ff != ST_CLEAR, state_ff != ST_CLEAR, "clear pass re-entered")

endmodule

[design/pecb_datapath.sv]
// Datapath of the profile event counter bank: counter memory, checks and update.
`include "profile_event_counter_bank_macros.svh"

module pecb_datapath #(
   parameter int SLOTS = pecb_pkg::PECB_SLOTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pecb_pkg::req_type                     req_data,
   input  pecb_pkg::cmd_type                     cmd,
   output pecb_pkg::status_type                  status,
   input  logic                                  csr_write_enable,
   input  logic [1:0]                            csr_index,
   input  logic [pecb_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pecb_pkg::rsp_type                     rsp_data
);
   import pecb_pkg::*;

   localparam int              AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [31:0]     SLOTS_W   = 32'(SLOTS);
   localparam logic [AW-1:0]   LAST_SLOT = AW'(SLOTS - 1);

   // Configuration registers.
   logic                   capture_enable_ff;
   logic [COUNT_WIDTH-1:0] function_count_ff;
   logic [COUNT_WIDTH-1:0] call_site_count_ff;

   // Request and pipeline registers.
   req_type       req_ff;
   logic [1:0]    op_ff;
   logic [1:0]    op_in;
   logic [AW-1:0] slot_ff;
   logic [AW-1:0] slot_in;
   logic [63:0]   rd_data_ff;
   logic [AW-1:0] clear_addr_ff;

   // Sticky flags and result register.
   logic    overflow_flag_ff;
   logic    overflow_flag_in;
   logic    invalid_flag_ff;
   logic    invalid_flag_in;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Counter memory.
   logic [63:0]   mem [SLOTS];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [63:0]   mem_wdata;

   logic [31:0]            raw;
   logic                   negative;
   logic                   is_entry;
   logic [COUNT_WIDTH-1:0] limit;
   logic [COUNT_WIDTH-1:0] base;
   logic [31:0]            slot_sum;
   logic [31:0]            slot_sel;
   logic                   at_max;
   logic [63:0]            incremented;

   // Configuration writes; an index beyond the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         capture_enable_ff  <= 1'b0;
         function_count_ff  <= '0;
         call_site_count_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CAPTURE_ENABLE:  capture_enable_ff  <= csr_write_data[0];
            CSR_FUNCTION_COUNT:  function_count_ff  <= csr_write_data;
            CSR_CALL_SITE_COUNT: call_site_count_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Index check: region bounds (events only), then the absolute slot against the store size.
   always_comb begin
      raw      = req_ff.index;
      negative = raw[31];
      is_entry = (req_ff.action == ACT_ENTRY);
      limit    = is_entry ? function_count_ff : call_site_count_ff;
      base     = is_entry ? '0 : function_count_ff;
      slot_sum = {{(32-COUNT_WIDTH){1'b0}}, base} + raw;
      op_in    = OP_NONE;
      slot_sel = raw;
      case (req_ff.action)
         ACT_READ: begin
            if (!negative && raw < SLOTS_W) begin
               op_in = OP_READ;
            end
         end
         ACT_ENTRY, ACT_CALL: begin
            slot_sel = slot_sum;
            if (capture_enable_ff) begin
               if (negative || raw >= {{(32-COUNT_WIDTH){1'b0}}, limit}
                   || slot_sum >= SLOTS_W) begin
                  op_in = OP_BAD;
               end else begin
                  op_in = OP_BUMP;
               end
            end
         end
         default: begin
            op_in = OP_NONE;
         end
      endcase
      slot_in = slot_sel[AW-1:0];
   end

   // Update of the addressed counter and the response.
   always_comb begin
      at_max           = (rd_data_ff == '1);
      incremented      = rd_data_ff + 64'd1;
      overflow_flag_in = overflow_flag_ff;
      invalid_flag_in  = invalid_flag_ff;
      rsp_in           = '0;
      case (op_ff)
         OP_READ: begin
            rsp_in.count_value = rd_data_ff;
         end
         OP_BAD: begin
            invalid_flag_in = 1'b1;
         end
         OP_BUMP: begin
            if (at_max) begin
               overflow_flag_in   = 1'b1;
               rsp_in.count_value = '1;
            end else begin
               rsp_in.count_value = incremented;
               rsp_in.counted     = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_in.overflow_seen = overflow_flag_in;
      rsp_in.invalid_seen  = invalid_flag_in;
   end

   // Memory write port is shared by the clearing pass and counter updates.
   always_comb begin
      mem_we    = cmd.clear_step || (cmd.exec && op_ff == OP_BUMP && !at_max);
      mem_waddr = cmd.clear_step ? clear_addr_ff : slot_ff;
      mem_wdata = cmd.clear_step ? '0 : incremented;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // Registered memory read.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[slot_ff];
      end
   end

   // Payload registers of the request in flight.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.check) begin
         op_ff   <= op_in;
         slot_ff <= slot_in;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // Clear address, sticky flags and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff    <= '0;
         overflow_flag_ff <= 1'b0;
         invalid_flag_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clear_addr_ff <= clear_addr_ff + AW'(1);
         end
         if (cmd.exec) begin
            overflow_flag_ff <= overflow_flag_in;
            invalid_flag_ff  <= invalid_flag_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = (clear_addr_ff == LAST_SLOT);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;

   // Flags are sticky, and a counted event never reports zero.
   `PECB_ASSERT_NEXT(a_overflow_sticky, overflow_flag_ff, overflow_flag_ff, "overflow flag fell")
   `PECB_ASSERT_NEXT(a_invalid_sticky, invalid_flag_ff, invalid_flag_ff, "invalid flag fell")
   `PECB_ASSERT_NOW(a_counted_nonzero, rsp_valid_ff && rsp_ff.counted, rsp_ff.count_value != 64'd0, "counted with zero value")
   `PECB_ASSERT_NOW(a_clear_excl, cmd.clear_step, !cmd.exec && !cmd.load, "request work during clear")

endmodule

[design/profile_event_counter_bank.sv]
// Profile event counter bank: SLOTS saturating 64-bit counters in one memory.
// Each request holds the controller through its steps (accept, index check, memory
// read, update and write back), which run one after another because of the
// read-modify-write of the single counter memory. The response is registered at
// the update step, and the next request can be accepted in the cycle in which it
// becomes valid, so a request is taken only after the previous one is updated.
// A stalled response holds back only the update step of the following request.
// After reset a clearing pass writes zero to every slot, one slot per cycle,
// during which req_ready stays low; configuration writes are taken at any time.
module profile_event_counter_bank #(
   parameter int SLOTS = pecb_pkg::PECB_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pecb_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pecb_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [1:0]                          csr_index,
   input  logic [pecb_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import pecb_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing of the clearing pass and of each request.
   pecb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Counter memory, configuration, checks and response register.
   pecb_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule

[test/testbench.sv]
// Self-checking testbench for the profile event counter bank: directed and random requests.
`timescale 1ns / 100ps

module testbench;
   import pecb_pkg::*;

   localparam int SLOT_COUNT = PECB_SLOTS;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 1500;
   localparam int CALM_OPS = 150;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 20;
   localparam int TIMEOUT_NS = 5_000_000;

   // One queued operation: either a register write or a request.
   typedef struct {
      bit                        is_csr;
      logic [1:0]                csr_sel;
      logic [CSR_DATA_WIDTH-1:0] csr_value;
      req_type                   req;
   } bank_op_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_enable = 1'b0;
   logic [1:0]                csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   // Shadow copy of the counter store, flags and registers.
   logic [63:0]            slot_count [SLOT_COUNT];
   logic                   capture_on = 1'b0;
   logic [COUNT_WIDTH-1:0] entry_limit = '0;
   logic [COUNT_WIDTH-1:0] call_limit = '0;
   logic                   overflow_state = 1'b0;
   logic                   invalid_state = 1'b0;

   bank_op_type queued_ops[$];
   rsp_type     predicted_rsp[$];
   int          error_count = 0;

   // Driver and monitor bookkeeping.
   logic    calm_tail = 1'b0;
   logic    valid_next;
   logic    csr_we_next;
   int      req_gap_left = 0;
   int      req_run_left = 0;
   int      settle_left = 0;
   int      rsp_stall_left = 0;
   int      rsp_run_left = 0;
   rsp_type rsp_want;

   profile_event_counter_bank i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one request to the shadow store and returns the response it must produce.
   // Saturation cannot be reached from a cleared store, but it is modeled all the same.
   function automatic rsp_type predict_counter_event(input req_type r);
      rsp_type     res;
      logic [31:0] raw;
      logic [31:0] limit;
      logic [31:0] base;
      logic [31:0] slot;
      res = '0;
      raw = r.index;
      if (r.action == ACT_READ) begin
         if (!raw[31] && raw < SLOT_COUNT) res.count_value = slot_count[raw];
      end else if ((r.action == ACT_ENTRY || r.action == ACT_CALL) && capture_on) begin
         limit = (r.action == ACT_ENTRY) ? 32'(entry_limit) : 32'(call_limit);
         base = (r.action == ACT_ENTRY) ? 32'd0 : 32'(entry_limit);
         slot = base + raw;
         if (raw[31] || raw >= limit || slot >= SLOT_COUNT) begin
            invalid_state = 1'b1;
         end else if (slot_count[slot] == '1) begin
            overflow_state = 1'b1;
            res.count_value = '1;
         end else begin
            slot_count[slot] = slot_count[slot] + 64'd1;
            res.count_value = slot_count[slot];
            res.counted = 1'b1;
         end
      end
      res.overflow_seen = overflow_state;
      res.invalid_seen = invalid_state;
      return res;
   endfunction

   // Region sizes lean small so that counters climb, with the extremes mixed in.
   function automatic logic [CSR_DATA_WIDTH-1:0] random_region_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2, 3, 4: return CSR_DATA_WIDTH'($urandom_range(1, 8));
         5, 6: return CSR_DATA_WIDTH'($urandom_range(9, 64));
         7: return CSR_DATA_WIDTH'(4096);
         8: return CSR_DATA_WIDTH'($urandom_range(0, 4096));
         default: return CSR_DATA_WIDTH'($urandom_range(4097, 8191));
      endcase
   endfunction

   task automatic queue_csr(input logic [1:0] sel, input logic [CSR_DATA_WIDTH-1:0] value);
      bank_op_type op;
      op = '{is_csr: 1'b1, csr_sel: sel, csr_value: value, req: '0};
      queued_ops.push_back(op);
   endtask

   task automatic queue_req(input logic [1:0] action, input logic [31:0] index);
      bank_op_type op;
      op = '{is_csr: 1'b0, csr_sel: '0, csr_value: '0, req: '{action: action, index: index}};
      queued_ops.push_back(op);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Driver: presents queued requests and performs register writes once the bank is idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_write_enable <= 1'b0;
      end else begin
         valid_next = req_valid;
         csr_we_next = 1'b0;
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(predict_counter_event(req_data));
            valid_next = 1'b0;
            if (!calm_tail) begin
               if (req_run_left > 0) begin
                  req_run_left--;
               end else begin
                  req_gap_left = $urandom_range(1, 16);
                  req_run_left = $urandom_range(0, 40);
               end
            end
         end
         if (!valid_next && queued_ops.size() > 0) begin
            if (req_gap_left > 0 && !calm_tail) begin
               req_gap_left--;
            end else if (queued_ops[0].is_csr) begin
               // Register writes wait until every response is back and the pipeline drained.
               if (predicted_rsp.size() != 0 || req_valid) begin
                  settle_left = SETTLE_CYCLES;
               end else if (settle_left > 0) begin
                  settle_left--;
               end else begin
                  csr_we_next = 1'b1;
                  csr_index <= queued_ops[0].csr_sel;
                  csr_write_data <= queued_ops[0].csr_value;
                  case (queued_ops[0].csr_sel)
                     CSR_CAPTURE_ENABLE: capture_on = queued_ops[0].csr_value[0];
                     CSR_FUNCTION_COUNT: entry_limit = queued_ops[0].csr_value;
                     CSR_CALL_SITE_COUNT: call_limit = queued_ops[0].csr_value;
                     default: ;
                  endcase
                  void'(queued_ops.pop_front());
               end
            end else begin
               req_data <= queued_ops[0].req;
               valid_next = 1'b1;
               void'(queued_ops.pop_front());
            end
         end
         req_valid <= valid_next;
         csr_write_enable <= csr_we_next;
         calm_tail <= (queued_ops.size() < CALM_OPS);
      end
   end

   // Monitor: checks each response against the oldest prediction and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("response with no request outstanding: count_value %0h",
                      rsp_data.count_value);
               error_count++;
            end else begin
               rsp_want = predicted_rsp.pop_front();
               check_field("count_value", rsp_want.count_value, rsp_data.count_value);
               check_field("counted", 64'(rsp_want.counted), 64'(rsp_data.counted));
               check_field("overflow_seen", 64'(rsp_want.overflow_seen),
                           64'(rsp_data.overflow_seen));
               check_field("invalid_seen", 64'(rsp_want.invalid_seen),
                           64'(rsp_data.invalid_seen));
            end
         end
         if (rsp_stall_left > 0 && !calm_tail) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm_tail) begin
               if (rsp_run_left > 0) begin
                  rsp_run_left--;
               end else begin
                  rsp_stall_left = $urandom_range(1, 16);
                  rsp_run_left = $urandom_range(0, 40);
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int                        random_left;
      int                        phase_items;
      int                        pick;
      logic [CSR_DATA_WIDTH-1:0] fcount;
      logic [CSR_DATA_WIDTH-1:0] ccount;
      logic                      capture;
      logic [1:0]                action;
      logic [31:0]               index;

      foreach (slot_count[i]) slot_count[i] = '0;

      // Small regions: three functions, two call sites in slots three and four.
      queue_csr(CSR_CAPTURE_ENABLE, 13'd1);
      queue_csr(CSR_FUNCTION_COUNT, 13'd3);
      queue_csr(CSR_CALL_SITE_COUNT, 13'd2);
      queue_csr(CSR_UNUSED, 13'h1fff);
      queue_req(ACT_READ, 32'd0);
      queue_req(ACT_ENTRY, 32'd0);
      queue_req(ACT_ENTRY, 32'd0);
      queue_req(ACT_ENTRY, 32'd2);
      queue_req(ACT_ENTRY, 32'd3);
      queue_req(ACT_ENTRY, 32'hffff_ffff);
      queue_req(ACT_CALL, 32'd0);
      queue_req(ACT_CALL, 32'd1);
      queue_req(ACT_CALL, 32'd2);
      queue_req(ACT_CALL, 32'h8000_0000);
      queue_req(ACT_CALL, 32'h7fff_ffff);
      queue_req(ACT_READ, 32'd0);
      queue_req(ACT_READ, 32'd4095);
      queue_req(ACT_READ, 32'd4096);
      queue_req(ACT_READ, 32'hffff_ffff);
      queue_req(ACT_READ, 32'h7fff_ffff);
      queue_req(ACT_UNUSED, 32'd0);

      // Capture off: events are dropped but reads still work.
      queue_csr(CSR_CAPTURE_ENABLE, 13'd0);
      queue_req(ACT_ENTRY, 32'd0);
      queue_req(ACT_CALL, 32'd0);
      queue_req(ACT_READ, 32'd3);

      // Full-size regions: the call site region starts past the end of the store.
      queue_csr(CSR_CAPTURE_ENABLE, 13'd1);
      queue_csr(CSR_FUNCTION_COUNT, 13'd4096);
      queue_csr(CSR_CALL_SITE_COUNT, 13'd4096);
      queue_req(ACT_ENTRY, 32'd4095);
      queue_req(ACT_CALL, 32'd0);
      queue_req(ACT_ENTRY, 32'd4096);

      // Empty function region and an oversized call site region.
      queue_csr(CSR_FUNCTION_COUNT, 13'd0);
      queue_csr(CSR_CALL_SITE_COUNT, 13'h1fff);
      queue_req(ACT_CALL, 32'd4095);
      queue_req(ACT_CALL, 32'd4096);
      queue_req(ACT_ENTRY, 32'd0);

      // Random phases, each with its own register settings.
      random_left = RANDOM_REQUESTS;
      while (random_left > 0) begin
         capture = ($urandom_range(0, 7) != 0);
         fcount = random_region_size();
         ccount = random_region_size();
         queue_csr(CSR_CAPTURE_ENABLE, {12'($urandom_range(0, 4095)), capture});
         queue_csr(CSR_FUNCTION_COUNT, fcount);
         queue_csr(CSR_CALL_SITE_COUNT, ccount);
         if ($urandom_range(0, 3) == 0) queue_csr(CSR_UNUSED, CSR_DATA_WIDTH'($urandom));
         phase_items = capture ? $urandom_range(60, 160) : $urandom_range(10, 30);
         repeat (phase_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && fcount != 0) begin
               queue_req(ACT_ENTRY, $urandom_range(0, fcount - 1));
            end else if (pick < 75 && ccount != 0) begin
               queue_req(ACT_CALL, $urandom_range(0, ccount - 1));
            end else if (pick < 85) begin
               queue_req(ACT_READ, $urandom_range(0, fcount + ccount + 1));
            end else begin
               // Noise: any action, with wild or boundary indexes.
               action = 2'($urandom_range(0, 3));
               case ($urandom_range(0, 3))
                  0: index = $urandom;
                  1: index = (action == ACT_CALL) ? 32'(ccount) : 32'(fcount);
                  2: index = -$urandom_range(1, 4);
                  default: index = $urandom_range(0, 4100);
               endcase
               queue_req(action, index);
            end
         end
         if (capture) random_left -= phase_items;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (queued_ops.size() != 0 || req_valid || predicted_rsp.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
